[hdl/multi_slot_software_timer_bank_unit_assert.svh]
// assertion macros for the timer bank rtl
// no dependencies; included by the modules that carry checks
`ifndef MULTI_SLOT_SOFTWARE_TIMER_BANK_UNIT_ASSERT_SVH
`define MULTI_SLOT_SOFTWARE_TIMER_BANK_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MSSTB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define MSSTB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define MSSTB_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define MSSTB_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[hdl/msstb_pkg.sv]
// shared types, codes and constants of the timer bank
// no dependencies
`default_nettype none
package msstb_pkg;

   localparam int TIMER_SLOTS_DEF = 8;
   localparam int TICK_BITS_DEF   = 32;
   localparam int MAX_SLOTS       = 8;
   localparam int DATA_W          = 32;
   localparam int OP_W            = 3;
   localparam int SLOT_W          = 3;
   localparam int STATUS_W        = 2;

   typedef logic [OP_W-1:0]     opcode_type;
   typedef logic [STATUS_W-1:0] status_type;

   localparam opcode_type OP_TICK   = 3'd0;
   localparam opcode_type OP_CREATE = 3'd1;
   localparam opcode_type OP_DELETE = 3'd2;
   localparam opcode_type OP_START  = 3'd3;
   localparam opcode_type OP_STOP   = 3'd4;
   localparam opcode_type OP_QUERY  = 3'd5;
   localparam opcode_type OP_CHECK  = 3'd6;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_NOT_ALLOC = 2'd1;
   localparam status_type STATUS_NO_FREE   = 2'd2;

   localparam logic KIND_DONE   = 1'b0;
   localparam logic KIND_EXPIRY = 1'b1;

   // write command towards the slot store
   typedef struct packed {
      logic wr_en;
      logic alloc;
      logic active;
      logic recur;
   } slot_ctl_type;

   // slot ids are three bits wide, so the bank never holds more than eight
   function automatic int slot_count(input int slots);
      int n;
      n = (slots < MAX_SLOTS) ? slots : MAX_SLOTS;
      return n;
   endfunction

endpackage
`default_nettype wire

[hdl/msstb_if.sv]
// request and response channel interfaces of the timer bank
// depends on msstb_pkg
`default_nettype none
interface msstb_req_if;
   logic                         valid;
   logic                         ready;
   logic [msstb_pkg::OP_W-1:0]   opcode;
   logic [msstb_pkg::SLOT_W-1:0] slot_id;
   logic [msstb_pkg::DATA_W-1:0] tick_duration;
   logic                         repeat_mode;
   logic [msstb_pkg::DATA_W-1:0] owner_tag;
   logic [msstb_pkg::DATA_W-1:0] begin_tick;

   modport source (output valid, opcode, slot_id, tick_duration, repeat_mode,
                   owner_tag, begin_tick, input ready);
   modport sink (input valid, opcode, slot_id, tick_duration, repeat_mode,
                 owner_tag, begin_tick, output ready);
endinterface

interface msstb_rsp_if;
   logic                           valid;
   logic                           ready;
   logic                           result_kind;
   logic [msstb_pkg::STATUS_W-1:0] status_code;
   logic [msstb_pkg::SLOT_W-1:0]   slot_number;
   logic [msstb_pkg::DATA_W-1:0]   tag_out;
   logic                           is_running;
   logic                           has_expired;
   logic [msstb_pkg::DATA_W-1:0]   tick_now;
   logic                           last_result;

   modport source (output valid, result_kind, status_code, slot_number, tag_out,
                   is_running, has_expired, tick_now, last_result, input ready);
   modport sink (input valid, result_kind, status_code, slot_number, tag_out,
                 is_running, has_expired, tick_now, last_result, output ready);
endinterface
`default_nettype wire

[hdl/msstb_expiry_unit.sv]
// shared expiry compare: wraparound elapsed ticks against a duration
// depends on msstb_pkg
`default_nettype none
module msstb_expiry_unit #(
   parameter int TICK_BITS = msstb_pkg::TICK_BITS_DEF
) (
   input  wire logic [TICK_BITS-1:0]         tick_now,
   input  wire logic [msstb_pkg::DATA_W-1:0] start_tick,
   input  wire logic [msstb_pkg::DATA_W-1:0] duration,
   output logic                              reached
);

   logic [TICK_BITS-1:0] elapsed;

   // subtraction wraps at the counter width by construction
   assign elapsed = tick_now - start_tick[TICK_BITS-1:0];
   assign reached = (msstb_pkg::DATA_W'(elapsed) >= duration);

endmodule
`default_nettype wire

[hdl/msstb_slot_store.sv]
// per-slot flags and payload registers, one read index and one write index
// depends on msstb_pkg
`default_nettype none
module msstb_slot_store #(
   parameter int SLOT_COUNT = msstb_pkg::TIMER_SLOTS_DEF,
   parameter int TICK_BITS  = msstb_pkg::TICK_BITS_DEF,
   parameter int IDX_W      = 3
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic [IDX_W-1:0]             rd_idx,
   output logic                              rd_alloc,
   output logic                              rd_active,
   output logic                              rd_recur,
   output logic [TICK_BITS-1:0]              rd_start,
   output logic [msstb_pkg::DATA_W-1:0]      rd_dur,
   output logic [msstb_pkg::DATA_W-1:0]      rd_tag,
   output logic [SLOT_COUNT-1:0]             alloc_vec,
   input  wire logic [IDX_W-1:0]             wr_idx,
   input  wire msstb_pkg::slot_ctl_type      wr_ctl,
   input  wire logic [TICK_BITS-1:0]         wr_start,
   input  wire logic [msstb_pkg::DATA_W-1:0] wr_dur,
   input  wire logic [msstb_pkg::DATA_W-1:0] wr_tag
);

   logic [SLOT_COUNT-1:0]        alloc_ff,  alloc_in;
   logic [SLOT_COUNT-1:0]        active_ff, active_in;
   logic [SLOT_COUNT-1:0]        recur_ff,  recur_in;
   logic [TICK_BITS-1:0]         start_ff [SLOT_COUNT];
   logic [msstb_pkg::DATA_W-1:0] dur_ff   [SLOT_COUNT];
   logic [msstb_pkg::DATA_W-1:0] tag_ff   [SLOT_COUNT];

   always_comb begin
      alloc_in  = alloc_ff;
      active_in = active_ff;
      recur_in  = recur_ff;
      if (wr_ctl.wr_en) begin
         alloc_in[wr_idx]  = wr_ctl.alloc;
         active_in[wr_idx] = wr_ctl.active;
         recur_in[wr_idx]  = wr_ctl.recur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alloc_ff  <= '0;
         active_ff <= '0;
         recur_ff  <= '0;
      end else begin
         alloc_ff  <= alloc_in;
         active_ff <= active_in;
         recur_ff  <= recur_in;
      end
   end

   // payload is only read behind a set allocated flag
   always_ff @(posedge clock) begin
      if (wr_ctl.wr_en) begin
         start_ff[wr_idx] <= wr_start;
         dur_ff[wr_idx]   <= wr_dur;
         tag_ff[wr_idx]   <= wr_tag;
      end
   end

   assign rd_alloc  = alloc_ff[rd_idx];
   assign rd_active = active_ff[rd_idx];
   assign rd_recur  = recur_ff[rd_idx];
   assign rd_start  = start_ff[rd_idx];
   assign rd_dur    = dur_ff[rd_idx];
   assign rd_tag    = tag_ff[rd_idx];
   assign alloc_vec = alloc_ff;

endmodule
`default_nettype wire

[hdl/multi_slot_software_timer_bank_unit.sv]
// top level of the timer bank: sequencer, tick counter and response register
// depends on msstb_pkg, msstb_if, msstb_slot_store, msstb_expiry_unit
//
// Timer bank with up to eight slots and a tick counter that advances on each tick request.
// One request word is taken at a time. A tick request is accepted, then the slots (TIMER_SLOTS,
// capped at eight) are walked one at a time through the single elapsed-time compare unit, then
// the completion word is issued; every other opcode is accepted and then issues its completion
// word. A response word that is due waits while the response register is still held by the sink.
// Expiry words leave in ascending slot order, and each request ends with exactly one completion
// word with last_result set. The response register lets the next request be taken while the final
// word of the previous one still waits.
`default_nettype none
`include "multi_slot_software_timer_bank_unit_assert.svh"
module multi_slot_software_timer_bank_unit #(
   parameter int TIMER_SLOTS = msstb_pkg::TIMER_SLOTS_DEF,
   parameter int TICK_BITS   = msstb_pkg::TICK_BITS_DEF
) (
   input wire logic    clock,
   input wire logic    reset,
   msstb_req_if.sink   req_ch,
   msstb_rsp_if.source rsp_ch
);

   localparam int SlotCount = msstb_pkg::slot_count(TIMER_SLOTS);
   localparam int IdxW      = (SlotCount > 1) ? $clog2(SlotCount) : 1;

   typedef enum logic [2:0] {
      S_IDLE   = 3'b001,
      S_SCAN   = 3'b010,
      S_FINISH = 3'b100
   } state_type;

   state_type                      state_ff, state_in;
   logic [msstb_pkg::OP_W-1:0]     op_ff, op_in;
   logic [msstb_pkg::SLOT_W-1:0]   sid_ff, sid_in;
   logic [msstb_pkg::DATA_W-1:0]   dur_ff, dur_in;
   logic                           rep_ff, rep_in;
   logic [msstb_pkg::DATA_W-1:0]   tag_ff, tag_in;
   logic [msstb_pkg::DATA_W-1:0]   begin_ff, begin_in;
   logic [IdxW-1:0]                idx_ff, idx_in;
   logic [TICK_BITS-1:0]           tick_ff, tick_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           kind_ff, kind_in;
   logic [msstb_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [msstb_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [msstb_pkg::DATA_W-1:0]   tago_ff, tago_in;
   logic                           run_ff, run_in;
   logic                           exp_ff, exp_in;
   logic [TICK_BITS-1:0]           rtick_ff, rtick_in;
   logic                           last_ff, last_in;

   logic                           accept;
   logic                           out_free;
   logic [IdxW-1:0]                rd_idx;
   logic                           rd_alloc, rd_active, rd_recur;
   logic [TICK_BITS-1:0]           rd_start;
   logic [msstb_pkg::DATA_W-1:0]   rd_dur, rd_tag;
   logic [SlotCount-1:0]           alloc_vec;
   logic [IdxW-1:0]                wr_idx;
   msstb_pkg::slot_ctl_type        wr_ctl;
   logic [TICK_BITS-1:0]           wr_start;
   logic [msstb_pkg::DATA_W-1:0]   wr_dur, wr_tag;
   logic [msstb_pkg::DATA_W-1:0]   cmp_start, cmp_dur;
   logic                           reached;
   logic                           sid_ok;
   logic                           expire;
   logic                           free_found;
   logic [IdxW-1:0]                free_idx;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign out_free     = !rsp_valid_ff || rsp_ch.ready;

   assign rd_idx = (state_ff == S_SCAN) ? idx_ff : sid_ff[IdxW-1:0];
   assign sid_ok = (int'(sid_ff) < SlotCount) && rd_alloc;
   assign expire = rd_alloc && rd_active && reached;

   msstb_slot_store #(
      .SLOT_COUNT (SlotCount),
      .TICK_BITS  (TICK_BITS),
      .IDX_W      (IdxW)
   ) u_store (
      .clock     (clock),
      .reset     (reset),
      .rd_idx    (rd_idx),
      .rd_alloc  (rd_alloc),
      .rd_active (rd_active),
      .rd_recur  (rd_recur),
      .rd_start  (rd_start),
      .rd_dur    (rd_dur),
      .rd_tag    (rd_tag),
      .alloc_vec (alloc_vec),
      .wr_idx    (wr_idx),
      .wr_ctl    (wr_ctl),
      .wr_start  (wr_start),
      .wr_dur    (wr_dur),
      .wr_tag    (wr_tag)
   );

   // standalone check uses the request operands, the scan uses the slot
   always_comb begin
      if (state_ff == S_FINISH && op_ff == msstb_pkg::OP_CHECK) begin
         cmp_start = begin_ff;
         cmp_dur   = dur_ff;
      end else begin
         cmp_start = msstb_pkg::DATA_W'(rd_start);
         cmp_dur   = rd_dur;
      end
   end

   msstb_expiry_unit #(
      .TICK_BITS (TICK_BITS)
   ) u_expiry (
      .tick_now   (tick_ff),
      .start_tick (cmp_start),
      .duration   (cmp_dur),
      .reached    (reached)
   );

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SlotCount - 1; i >= 0; i--) begin
         if (!alloc_vec[i]) begin
            free_found = 1'b1;
            free_idx   = IdxW'(i);
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      sid_in       = sid_ff;
      dur_in       = dur_ff;
      rep_in       = rep_ff;
      tag_in       = tag_ff;
      begin_in     = begin_ff;
      idx_in       = idx_ff;
      tick_in      = tick_ff;

      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      status_in    = status_ff;
      slot_in      = slot_ff;
      tago_in      = tago_ff;
      run_in       = run_ff;
      exp_in       = exp_ff;
      rtick_in     = rtick_ff;
      last_in      = last_ff;

      wr_idx        = rd_idx;
      wr_ctl.wr_en  = 1'b0;
      wr_ctl.alloc  = rd_alloc;
      wr_ctl.active = rd_active;
      wr_ctl.recur  = rd_recur;
      wr_start      = rd_start;
      wr_dur        = rd_dur;
      wr_tag        = rd_tag;

      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_ch.opcode;
               sid_in   = req_ch.slot_id;
               dur_in   = req_ch.tick_duration;
               rep_in   = req_ch.repeat_mode;
               tag_in   = req_ch.owner_tag;
               begin_in = req_ch.begin_tick;
               idx_in   = '0;
               if (req_ch.opcode == msstb_pkg::OP_TICK) begin
                  tick_in  = tick_ff + 1'b1;
                  state_in = S_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end
         S_SCAN: begin
            // hold the slot while an expiry word cannot be placed
            if (!expire || out_free) begin
               if (expire) begin
                  rsp_valid_in  = 1'b1;
                  kind_in       = msstb_pkg::KIND_EXPIRY;
                  status_in     = msstb_pkg::STATUS_OK;
                  slot_in       = msstb_pkg::SLOT_W'(idx_ff);
                  tago_in       = rd_tag;
                  run_in        = 1'b0;
                  exp_in        = 1'b0;
                  rtick_in      = tick_ff;
                  last_in       = 1'b0;
                  wr_ctl.wr_en  = 1'b1;
                  if (rd_recur) begin
                     wr_start = tick_ff;
                  end else begin
                     wr_ctl.active = 1'b0;
                     wr_start      = '0;
                     wr_dur        = '0;
                  end
               end
               if (idx_ff == IdxW'(SlotCount - 1)) begin
                  state_in = S_FINISH;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               kind_in      = msstb_pkg::KIND_DONE;
               status_in    = msstb_pkg::STATUS_OK;
               slot_in      = sid_ff;
               tago_in      = '0;
               run_in       = 1'b0;
               exp_in       = 1'b0;
               rtick_in     = tick_ff;
               last_in      = 1'b1;
               state_in     = S_IDLE;
               case (op_ff)
                  msstb_pkg::OP_CREATE: begin
                     if (free_found) begin
                        slot_in       = msstb_pkg::SLOT_W'(free_idx);
                        wr_idx        = free_idx;
                        wr_ctl.wr_en  = 1'b1;
                        wr_ctl.alloc  = 1'b1;
                        wr_ctl.active = 1'b0;
                        wr_ctl.recur  = rep_ff;
                        wr_start      = '0;
                        wr_dur        = '0;
                        wr_tag        = tag_ff;
                     end else begin
                        status_in = msstb_pkg::STATUS_NO_FREE;
                        slot_in   = '0;
                     end
                  end
                  msstb_pkg::OP_DELETE: begin
                     if (sid_ok) begin
                        wr_ctl.wr_en  = 1'b1;
                        wr_ctl.alloc  = 1'b0;
                        wr_ctl.active = 1'b0;
                        wr_ctl.recur  = 1'b0;
                        wr_start      = '0;
                        wr_dur        = '0;
                        wr_tag        = '0;
                     end else begin
                        status_in = msstb_pkg::STATUS_NOT_ALLOC;
                     end
                  end
                  msstb_pkg::OP_START: begin
                     if (sid_ok) begin
                        wr_ctl.wr_en  = 1'b1;
                        wr_ctl.active = 1'b1;
                        wr_start      = tick_ff;
                        wr_dur        = dur_ff;
                     end else begin
                        status_in = msstb_pkg::STATUS_NOT_ALLOC;
                     end
                  end
                  msstb_pkg::OP_STOP: begin
                     if (sid_ok) begin
                        wr_ctl.wr_en  = 1'b1;
                        wr_ctl.active = 1'b0;
                        wr_start      = '0;
                        wr_dur        = '0;
                     end else begin
                        status_in = msstb_pkg::STATUS_NOT_ALLOC;
                     end
                  end
                  msstb_pkg::OP_QUERY: begin
                     run_in = sid_ok && rd_active;
                     if (!sid_ok) begin
                        status_in = msstb_pkg::STATUS_NOT_ALLOC;
                     end
                  end
                  msstb_pkg::OP_CHECK: begin
                     slot_in = '0;
                     exp_in  = reached;
                  end
                  default: begin
                     // tick completion and the reserved opcode
                     slot_in = '0;
                  end
               endcase
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         tick_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      sid_ff    <= sid_in;
      dur_ff    <= dur_in;
      rep_ff    <= rep_in;
      tag_ff    <= tag_in;
      begin_ff  <= begin_in;
      kind_ff   <= kind_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
      tago_ff   <= tago_in;
      run_ff    <= run_in;
      exp_ff    <= exp_in;
      rtick_ff  <= rtick_in;
      last_ff   <= last_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.result_kind = kind_ff;
   assign rsp_ch.status_code = status_ff;
   assign rsp_ch.slot_number = slot_ff;
   assign rsp_ch.tag_out     = tago_ff;
   assign rsp_ch.is_running  = run_ff;
   assign rsp_ch.has_expired = exp_ff;
   assign rsp_ch.tick_now    = msstb_pkg::DATA_W'(rtick_ff);
   assign rsp_ch.last_result = last_ff;

   `MSSTB_ASSERT_IMP(a_scan_idx_range, clock, reset, state_ff == S_SCAN, int'(idx_ff) < SlotCount, "scan index beyond slot count")
   `MSSTB_ASSERT_NXT(a_tick_advance, clock, reset, accept && req_ch.opcode == msstb_pkg::OP_TICK, tick_ff == TICK_BITS'($past(tick_ff) + 1'b1), "tick counter did not advance")
   `MSSTB_ASSERT_IMP(a_expiry_not_last, clock, reset, rsp_valid_ff && kind_ff == msstb_pkg::KIND_EXPIRY, !last_ff, "expiry word flagged as last")
   `MSSTB_ASSERT_NXT(a_finish_done, clock, reset, state_ff == S_FINISH && out_free, state_ff == S_IDLE && rsp_valid_ff && last_ff, "completion word not issued")

endmodule
`default_nettype wire

[sim/msstb_timer_checker.sv]
// response checker for the timer bank: tracks slot state and compares response words
// depends on msstb_pkg and msstb_if; watches both channels beside the unit under test
`default_nettype none
module msstb_timer_checker (
   input  wire logic clock,
   input  wire logic reset,
   msstb_req_if      req_mon,
   msstb_rsp_if      rsp_mon,
   output int        error_count,
   output int        pending_words,
   output int        expiry_seen,
   output int        done_seen
);

   typedef struct packed {
      logic                           kind;
      msstb_pkg::status_type          status;
      logic [msstb_pkg::SLOT_W-1:0]   slot;
      logic [msstb_pkg::DATA_W-1:0]   tag;
      logic                           running;
      logic                           expired;
      logic [msstb_pkg::DATA_W-1:0]   tick;
      logic                           last;
   } timer_word_type;

   logic [msstb_pkg::DATA_W-1:0] bank_tick;
   logic                         slot_used   [msstb_pkg::MAX_SLOTS];
   logic                         slot_armed  [msstb_pkg::MAX_SLOTS];
   logic                         slot_repeat [msstb_pkg::MAX_SLOTS];
   logic [msstb_pkg::DATA_W-1:0] slot_from   [msstb_pkg::MAX_SLOTS];
   logic [msstb_pkg::DATA_W-1:0] slot_len    [msstb_pkg::MAX_SLOTS];
   logic [msstb_pkg::DATA_W-1:0] slot_owner  [msstb_pkg::MAX_SLOTS];

   timer_word_type expected_words[$];
   timer_word_type got_word;
   timer_word_type want_word;
   int             mismatches  = 0;
   int             expiries    = 0;
   int             completions = 0;

   function automatic timer_word_type make_word(input logic kind,
                                                input msstb_pkg::status_type status,
                                                input logic [msstb_pkg::SLOT_W-1:0] slot,
                                                input logic [msstb_pkg::DATA_W-1:0] tag,
                                                input logic running, input logic expired);
      timer_word_type w;
      w.kind    = kind;
      w.status  = status;
      w.slot    = slot;
      w.tag     = tag;
      w.running = running;
      w.expired = expired;
      w.tick    = bank_tick;
      w.last    = (kind == msstb_pkg::KIND_DONE);
      return w;
   endfunction

   // elapsed ticks wrap with the counter
   function automatic logic reached(input logic [msstb_pkg::DATA_W-1:0] from,
                                    input logic [msstb_pkg::DATA_W-1:0] len);
      logic [msstb_pkg::DATA_W-1:0] elapsed;
      elapsed = bank_tick - from;
      return elapsed >= len;
   endfunction

   function automatic void wipe_slot(input int s);
      slot_used[s]   = 1'b0;
      slot_armed[s]  = 1'b0;
      slot_repeat[s] = 1'b0;
      slot_from[s]   = '0;
      slot_len[s]    = '0;
      slot_owner[s]  = '0;
   endfunction

   task automatic predict_request(input msstb_pkg::opcode_type op,
                                  input logic [msstb_pkg::SLOT_W-1:0] sid,
                                  input logic [msstb_pkg::DATA_W-1:0] len, input logic rep,
                                  input logic [msstb_pkg::DATA_W-1:0] tag,
                                  input logic [msstb_pkg::DATA_W-1:0] from);
      logic present;
      int   s;
      int   free_slot;
      present = slot_used[sid];
      case (op)
         msstb_pkg::OP_TICK: begin
            bank_tick = bank_tick + 1'b1;
            for (s = 0; s < msstb_pkg::MAX_SLOTS; s++) begin
               if (slot_used[s] && slot_armed[s] && reached(slot_from[s], slot_len[s])) begin
                  if (slot_repeat[s]) begin
                     slot_from[s] = bank_tick;
                  end else begin
                     slot_armed[s] = 1'b0;
                     slot_from[s]  = '0;
                     slot_len[s]   = '0;
                  end
                  expected_words.push_back(make_word(msstb_pkg::KIND_EXPIRY,
                                                     msstb_pkg::STATUS_OK,
                                                     msstb_pkg::SLOT_W'(s),
                                                     slot_owner[s], 1'b0, 1'b0));
               end
            end
            expected_words.push_back(make_word(msstb_pkg::KIND_DONE, msstb_pkg::STATUS_OK,
                                               '0, '0, 1'b0, 1'b0));
         end
         msstb_pkg::OP_CREATE: begin
            free_slot = msstb_pkg::MAX_SLOTS;
            for (s = msstb_pkg::MAX_SLOTS - 1; s >= 0; s--)
               if (!slot_used[s]) free_slot = s;
            if (free_slot < msstb_pkg::MAX_SLOTS) begin
               slot_used[free_slot]   = 1'b1;
               slot_armed[free_slot]  = 1'b0;
               slot_repeat[free_slot] = rep;
               slot_from[free_slot]   = '0;
               slot_len[free_slot]    = '0;
               slot_owner[free_slot]  = tag;
               expected_words.push_back(make_word(msstb_pkg::KIND_DONE, msstb_pkg::STATUS_OK,
                                                  msstb_pkg::SLOT_W'(free_slot),
                                                  '0, 1'b0, 1'b0));
            end else begin
               expected_words.push_back(make_word(msstb_pkg::KIND_DONE,
                                                  msstb_pkg::STATUS_NO_FREE, '0, '0,
                                                  1'b0, 1'b0));
            end
         end
         msstb_pkg::OP_DELETE: begin
            if (present) wipe_slot(sid);
            expected_words.push_back(make_word(msstb_pkg::KIND_DONE,
                                               present ? msstb_pkg::STATUS_OK
                                                       : msstb_pkg::STATUS_NOT_ALLOC,
                                               sid, '0, 1'b0, 1'b0));
         end
         msstb_pkg::OP_START: begin
            if (present) begin
               slot_armed[sid] = 1'b1;
               slot_from[sid]  = bank_tick;
               slot_len[sid]   = len;
            end
            expected_words.push_back(make_word(msstb_pkg::KIND_DONE,
                                               present ? msstb_pkg::STATUS_OK
                                                       : msstb_pkg::STATUS_NOT_ALLOC,
                                               sid, '0, 1'b0, 1'b0));
         end
         msstb_pkg::OP_STOP: begin
            if (present) begin
               slot_armed[sid] = 1'b0;
               slot_from[sid]  = '0;
               slot_len[sid]   = '0;
            end
            expected_words.push_back(make_word(msstb_pkg::KIND_DONE,
                                               present ? msstb_pkg::STATUS_OK
                                                       : msstb_pkg::STATUS_NOT_ALLOC,
                                               sid, '0, 1'b0, 1'b0));
         end
         msstb_pkg::OP_QUERY: begin
            expected_words.push_back(make_word(msstb_pkg::KIND_DONE,
                                               present ? msstb_pkg::STATUS_OK
                                                       : msstb_pkg::STATUS_NOT_ALLOC,
                                               sid, '0, present && slot_armed[sid], 1'b0));
         end
         msstb_pkg::OP_CHECK: begin
            expected_words.push_back(make_word(msstb_pkg::KIND_DONE, msstb_pkg::STATUS_OK,
                                               '0, '0, 1'b0, reached(from, len)));
         end
         default: begin
            // spare opcode: no effect, plain completion
            expected_words.push_back(make_word(msstb_pkg::KIND_DONE, msstb_pkg::STATUS_OK,
                                               '0, '0, 1'b0, 1'b0));
         end
      endcase
   endtask

   task automatic show_word(input string label, input timer_word_type w);
      $display("  %s: kind %0d status %0d slot %0d tag %h running %0d expired %0d",
               label, w.kind, w.status, w.slot, w.tag, w.running, w.expired);
      $display("      tick %h last %0d", w.tick, w.last);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         bank_tick = '0;
         for (int s = 0; s < msstb_pkg::MAX_SLOTS; s++) wipe_slot(s);
         expected_words.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            predict_request(req_mon.opcode, req_mon.slot_id, req_mon.tick_duration,
                            req_mon.repeat_mode, req_mon.owner_tag, req_mon.begin_tick);
         if (rsp_mon.valid && rsp_mon.ready) begin
            got_word = '{rsp_mon.result_kind, rsp_mon.status_code, rsp_mon.slot_number,
                         rsp_mon.tag_out, rsp_mon.is_running, rsp_mon.has_expired,
                         rsp_mon.tick_now, rsp_mon.last_result};
            if (got_word.kind == msstb_pkg::KIND_EXPIRY) expiries++;
            else completions++;
            if (expected_words.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("response word with nothing outstanding at %0t", $time);
                  show_word("actual", got_word);
               end
            end else begin
               want_word = expected_words.pop_front();
               if (got_word !== want_word) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("response word mismatch at %0t", $time);
                     show_word("expected", want_word);
                     show_word("actual  ", got_word);
                  end
               end
            end
         end
      end
      // registered so the stimulus side sees settled values
      error_count   <= mismatches;
      pending_words <= expected_words.size();
      expiry_seen   <= expiries;
      done_seen     <= completions;
   end

endmodule
`default_nettype wire

[sim/tb.sv]
// testbench top for the timer bank: clock, reset, request stimulus and response flow control
// depends on msstb_pkg, msstb_if, the bank rtl and msstb_timer_checker
`default_nettype none
module tb;

   localparam msstb_pkg::opcode_type OP_SPARE      = 3'd7;
   localparam int                    CYCLE_LIMIT   = 200000;
   localparam int                    HOLD_CYCLES   = 300;
   localparam int                    RANDOM_WORDS  = 200;
   localparam int                    SETTLE_CYCLES = 30;

   logic clock = 1'b0;
   logic reset;

   msstb_req_if req_ch();
   msstb_rsp_if rsp_ch();

   int error_count;
   int pending_words;
   int expiry_seen;
   int done_seen;
   int words_sent  = 0;
   int cycle_count = 0;
   bit calm        = 1'b0;
   bit want_hold   = 1'b0;

   always #10 clock = ~clock;

   multi_slot_software_timer_bank_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   msstb_timer_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .error_count   (error_count),
      .pending_words (pending_words),
      .expiry_seen   (expiry_seen),
      .done_seen     (done_seen)
   );

   task automatic offer_word(input msstb_pkg::opcode_type op,
                             input logic [msstb_pkg::SLOT_W-1:0] sid,
                             input logic [msstb_pkg::DATA_W-1:0] len, input logic rep,
                             input logic [msstb_pkg::DATA_W-1:0] tag,
                             input logic [msstb_pkg::DATA_W-1:0] from);
      req_ch.valid         <= 1'b1;
      req_ch.opcode        <= op;
      req_ch.slot_id       <= sid;
      req_ch.tick_duration <= len;
      req_ch.repeat_mode   <= rep;
      req_ch.owner_tag     <= tag;
      req_ch.begin_tick    <= from;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      words_sent++;
      if (!calm && $urandom_range(99) < 16) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (pending_words != 0);
   endtask

   // response side: random back-pressure, one long hold-off on request
   initial begin
      bit hold_done;
      hold_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (want_hold && !hold_done) begin
            rsp_ch.ready <= 1'b0;
            hold_done = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= calm || ($urandom_range(99) >= 16);
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run stopped at the cycle limit with %0d words outstanding", pending_words);
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      msstb_pkg::opcode_type        op;
      int                           pick;
      int                           i;
      logic [msstb_pkg::DATA_W-1:0] len;
      logic [msstb_pkg::DATA_W-1:0] from;
      logic [msstb_pkg::DATA_W-1:0] tag;
      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.opcode        <= msstb_pkg::OP_TICK;
      req_ch.slot_id       <= '0;
      req_ch.tick_duration <= '0;
      req_ch.repeat_mode   <= 1'b0;
      req_ch.owner_tag     <= '0;
      req_ch.begin_tick    <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // unallocated slots, spare opcode and wraparound checks on an empty bank
      offer_word(msstb_pkg::OP_QUERY, 3'd0, '0, 1'b0, '0, '0);
      offer_word(msstb_pkg::OP_START, 3'd7, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer_word(msstb_pkg::OP_STOP, 3'd3, '0, 1'b0, '0, '0);
      offer_word(msstb_pkg::OP_DELETE, 3'd5, '0, 1'b0, '0, '0);
      offer_word(OP_SPARE, 3'd7, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      offer_word(msstb_pkg::OP_CHECK, 3'd0, '0, 1'b0, '0, '0);
      offer_word(msstb_pkg::OP_CHECK, 3'd0, 32'd1, 1'b0, '0, 32'hFFFF_FFFF);
      offer_word(msstb_pkg::OP_CHECK, 3'd0, 32'hFFFF_FFFF, 1'b0, '0, '0);
      // fill the bank, then one create too many
      for (i = 0; i < msstb_pkg::MAX_SLOTS; i++) begin
         tag = (i == 0) ? 32'h0 : (i == 1) ? 32'hFFFF_FFFF : $urandom();
         offer_word(msstb_pkg::OP_CREATE, msstb_pkg::SLOT_W'(i), '0, i[0], tag, '0);
      end
      offer_word(msstb_pkg::OP_CREATE, 3'd0, '0, 1'b1, 32'hA5A5_5A5A, '0);
      // recurring zero duration fires every tick, one-shot fires once
      offer_word(msstb_pkg::OP_START, 3'd1, 32'd0, 1'b0, '0, '0);
      offer_word(msstb_pkg::OP_START, 3'd0, 32'd2, 1'b0, '0, '0);
      offer_word(msstb_pkg::OP_START, 3'd7, 32'hFFFF_FFFF, 1'b0, '0, '0);
      offer_word(msstb_pkg::OP_QUERY, 3'd1, '0, 1'b0, '0, '0);
      repeat (3) offer_word(msstb_pkg::OP_TICK, 3'd0, '0, 1'b0, '0, '0);
      offer_word(msstb_pkg::OP_STOP, 3'd1, '0, 1'b0, '0, '0);
      offer_word(msstb_pkg::OP_DELETE, 3'd0, '0, 1'b0, '0, '0);
      offer_word(msstb_pkg::OP_CREATE, 3'd0, '0, 1'b1, $urandom(), '0);

      for (i = 0; i < RANDOM_WORDS; i++) begin
         if (i == 60) want_hold <= 1'b1;
         if (i == 120) wait_for_drain();
         calm <= (i >= 140 && i < 180);
         pick = $urandom_range(99);
         if (pick < 40)      op = msstb_pkg::OP_TICK;
         else if (pick < 52) op = msstb_pkg::OP_CREATE;
         else if (pick < 57) op = msstb_pkg::OP_DELETE;
         else if (pick < 72) op = msstb_pkg::OP_START;
         else if (pick < 77) op = msstb_pkg::OP_STOP;
         else if (pick < 87) op = msstb_pkg::OP_QUERY;
         else if (pick < 97) op = msstb_pkg::OP_CHECK;
         else                op = OP_SPARE;
         // short durations so slots actually expire within the run
         pick = $urandom_range(99);
         if (pick < 70)      len = $urandom_range(12);
         else if (pick < 90) len = $urandom_range(300, 13);
         else                len = $urandom();
         from = $urandom_range(1) ? msstb_pkg::DATA_W'($urandom_range(400))
                                  : msstb_pkg::DATA_W'($urandom());
         offer_word(op, msstb_pkg::SLOT_W'($urandom_range(7)), len, 1'($urandom_range(1)),
                    $urandom(), from);
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("run covered %0d requests, answered by %0d expiry words and %0d completions",
               words_sent, expiry_seen, done_seen);
      if (error_count == 0 && pending_words == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("%0d response errors, %0d words outstanding", error_count, pending_words);
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

[filelist.f]
+incdir+hdl
hdl/msstb_pkg.sv
hdl/msstb_if.sv
hdl/msstb_expiry_unit.sv
hdl/msstb_slot_store.sv
hdl/multi_slot_software_timer_bank_unit.sv
sim/msstb_timer_checker.sv
sim/tb.sv
